@@ hw/rtl/mzht_pkg.sv @@
package mzht_pkg;

  // Zone count and field widths.
  localparam int unsigned ZONES     = 4;
  localparam int unsigned ZONE_W    = 2;
  localparam int unsigned TEMP_W    = 12;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned OUT_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  // Register reset values.
  localparam logic signed [TEMP_W-1:0] TurnOnTempRst   = 12'sd384;
  localparam logic signed [TEMP_W-1:0] TurnOffTempRst  = 12'sd400;
  localparam logic        [TIME_W-1:0] CheckIntervalRst = 32'd30000;
  localparam logic        [MASK_W-1:0] SensorMaskRst   = 4'hF;

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_READING     = 2'd1,
    ACT_SET_MODE    = 2'd2,
    ACT_TOGGLE_MODE = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURN_ON_TEMP    = 2'd0,
    CFG_TURN_OFF_TEMP   = 2'd1,
    CFG_CHECK_INTERVAL  = 2'd2,
    CFG_SENSOR_MASK     = 2'd3
  } cfg_idx_e;

  // Command presented to one zone for the beat being processed.
  typedef struct packed {
    logic                     fire;
    logic                     tick;
    logic                     reading;
    logic                     set_mode;
    logic                     toggle_mode;
    logic                     mode_req;
    logic [TIME_W-1:0]        now_ms;
    logic signed [TEMP_W-1:0] temperature;
    logic                     temp_valid;
    logic signed [TEMP_W-1:0] turn_on_temp;
    logic signed [TEMP_W-1:0] turn_off_temp;
    logic [TIME_W-1:0]        check_interval;
    logic                     has_sensor;
  } zone_cmd_t;

  // Status a zone reports after the beat.
  typedef struct packed {
    logic relay;
    logic mode;
    logic publish;
  } zone_stat_t;

endpackage

@@ hw/rtl/mzht_zone.sv @@
module mzht_zone (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mzht_pkg::zone_cmd_t cmd_i,
  output mzht_pkg::zone_stat_t stat_o
);
  import mzht_pkg::*;

  logic                     relay_q, relay_d;
  logic                     mode_q, mode_d;
  logic [TIME_W-1:0]        stamp_q, stamp_d;
  logic signed [TEMP_W-1:0] temp_q, temp_d;
  logic                     tvalid_q, tvalid_d;

  logic              due;
  logic              checking;
  logic              usable;
  logic              relay_ctl;
  logic              mode_target;
  logic              mode_change;
  logic [TIME_W-1:0] elapsed;

  always_comb begin
    elapsed  = cmd_i.now_ms - stamp_q;
    due      = (stamp_q == '0) || (elapsed >= cmd_i.check_interval);
    checking = cmd_i.fire && cmd_i.tick && mode_q && due;

    // Hysteresis: no sensor, no valid reading or a zero reading holds the relay.
    usable = cmd_i.has_sensor && tvalid_q && (temp_q != '0);
    if (!usable) begin
      relay_ctl = relay_q;
    end else if (relay_q) begin
      relay_ctl = !(temp_q >= cmd_i.turn_off_temp);
    end else begin
      relay_ctl = (temp_q < cmd_i.turn_on_temp);
    end

    mode_target = cmd_i.set_mode ? cmd_i.mode_req : !mode_q;
    mode_change = cmd_i.fire && (cmd_i.set_mode || cmd_i.toggle_mode) &&
                  (mode_target != mode_q);

    relay_d  = relay_q;
    mode_d   = mode_q;
    stamp_d  = stamp_q;
    temp_d   = temp_q;
    tvalid_d = tvalid_q;
    stat_o.publish = 1'b0;

    if (checking) begin
      stamp_d        = cmd_i.now_ms;
      relay_d        = relay_ctl;
      stat_o.publish = (relay_ctl != relay_q);
    end

    if (cmd_i.fire && cmd_i.reading) begin
      temp_d   = cmd_i.temperature;
      tvalid_d = cmd_i.temp_valid;
      stamp_d  = '0;
    end

    if (mode_change) begin
      mode_d         = mode_target;
      stat_o.publish = 1'b1;
      if (mode_target) begin
        stamp_d = '0;
      end else begin
        relay_d = 1'b0;
      end
    end

    stat_o.relay = relay_d;
    stat_o.mode  = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q  <= 1'b0;
      mode_q   <= 1'b0;
      stamp_q  <= '0;
      temp_q   <= '0;
      tvalid_q <= 1'b0;
    end else begin
      relay_q  <= relay_d;
      mode_q   <= mode_d;
      stamp_q  <= stamp_d;
      temp_q   <= temp_d;
      tvalid_q <= tvalid_d;
    end
  end

endmodule

@@ hw/rtl/multi_zone_hysteresis_thermostat.sv @@
// Four-zone on/off heating controller with hysteresis. Each input beat is
// one action: a tick carrying the millisecond time, a new temperature
// reading for one zone, or a set or toggle of one zone's mode. Every beat
// yields exactly one result beat holding the relay and mode bits of all
// zones after the action, plus a mask of the zones whose relay or mode
// changed. Throughput is one beat per clock: an accepted beat is held in an
// input register, and when the result register is free or being emptied
// the per-zone compare logic updates the zone state and loads the result
// register. The result beat is offered from that result register, behind
// the input register. A new beat may follow every cycle while out_ready_i
// is high. A stalled result holds the pipeline without losing anything.
// Temperatures are signed 1/16 degree values; the configuration registers
// may only be written while the block is idle.
module multi_zone_hysteresis_thermostat (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  // Configuration write port.
  input  logic                                  cfg_we_i,
  input  logic [mzht_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mzht_pkg::CFG_DAT_W-1:0]        cfg_wdata_i,

  // Input channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            action_i,
  input  logic [mzht_pkg::ZONE_W-1:0]           circle_i,
  input  logic [mzht_pkg::TIME_W-1:0]           now_ms_i,
  input  logic signed [mzht_pkg::TEMP_W-1:0]    temperature_i,
  input  logic                                  temp_valid_i,
  input  logic                                  mode_i,

  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mzht_pkg::OUT_W-1:0]            relay_bits_o,
  output logic [mzht_pkg::OUT_W-1:0]            mode_bits_o,
  output logic [mzht_pkg::OUT_W-1:0]            publish_mask_o
);
  import mzht_pkg::*;

  // Configuration registers.
  logic signed [TEMP_W-1:0] turn_on_q;
  logic signed [TEMP_W-1:0] turn_off_q;
  logic [TIME_W-1:0]        interval_q;
  logic [MASK_W-1:0]        sensor_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_on_q     <= TurnOnTempRst;
      turn_off_q    <= TurnOffTempRst;
      interval_q    <= CheckIntervalRst;
      sensor_mask_q <= SensorMaskRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TURN_ON_TEMP:   turn_on_q     <= cfg_wdata_i[TEMP_W-1:0];
        CFG_TURN_OFF_TEMP:  turn_off_q    <= cfg_wdata_i[TEMP_W-1:0];
        CFG_CHECK_INTERVAL: interval_q    <= cfg_wdata_i[TIME_W-1:0];
        CFG_SENSOR_MASK:    sensor_mask_q <= cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage. It advances whenever the result register is free
  // or being emptied in the same cycle.
  logic                     s1_valid_q;
  logic [1:0]               action_q;
  logic [ZONE_W-1:0]        circle_q;
  logic [TIME_W-1:0]        now_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     tvalid_q;
  logic                     mode_req_q;
  logic                     s1_fire;
  logic                     out_valid_q;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q   <= action_i;
      circle_q   <= circle_i;
      now_q      <= now_ms_i;
      temp_q     <= temperature_i;
      tvalid_q   <= temp_valid_i;
      mode_req_q <= mode_i;
    end
  end

  // Per-zone state and compare logic. Zones beyond the sensor mask width
  // count as having no sensor; a circle value naming no zone selects none.
  logic [ZONES-1:0] relay_vec;
  logic [ZONES-1:0] mode_vec;
  logic [ZONES-1:0] pub_vec;

  for (genvar z = 0; z < ZONES; z++) begin : g_zone
    zone_cmd_t  cmd;
    zone_stat_t stat;
    logic       sel;
    logic       sensor;

    if (z < MASK_W) begin : g_mask
      assign sensor = sensor_mask_q[z];
    end else begin : g_nomask
      assign sensor = 1'b0;
    end

    always_comb begin
      sel                = (int'(circle_q) == z);
      cmd.fire           = s1_fire;
      cmd.tick           = (action_e'(action_q) == ACT_TICK);
      cmd.reading        = sel && (action_e'(action_q) == ACT_READING);
      cmd.set_mode       = sel && (action_e'(action_q) == ACT_SET_MODE);
      cmd.toggle_mode    = sel && (action_e'(action_q) == ACT_TOGGLE_MODE);
      cmd.mode_req       = mode_req_q;
      cmd.now_ms         = now_q;
      cmd.temperature    = temp_q;
      cmd.temp_valid     = tvalid_q;
      cmd.turn_on_temp   = turn_on_q;
      cmd.turn_off_temp  = turn_off_q;
      cmd.check_interval = interval_q;
      cmd.has_sensor     = sensor;
    end

    mzht_zone u_zone (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .stat_o (stat)
    );

    assign relay_vec[z] = stat.relay;
    assign mode_vec[z]  = stat.mode;
    assign pub_vec[z]   = stat.publish;
  end

  // Result register. Only the first four zones appear on the outputs.
  logic [OUT_W-1:0] relay_out_d, mode_out_d, pub_out_d;
  logic [OUT_W-1:0] relay_out_q, mode_out_q, pub_out_q;

  for (genvar b = 0; b < OUT_W; b++) begin : g_out
    if (b < ZONES) begin : g_live
      assign relay_out_d[b] = relay_vec[b];
      assign mode_out_d[b]  = mode_vec[b];
      assign pub_out_d[b]   = pub_vec[b];
    end else begin : g_pad
      assign relay_out_d[b] = 1'b0;
      assign mode_out_d[b]  = 1'b0;
      assign pub_out_d[b]   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      relay_out_q <= relay_out_d;
      mode_out_q  <= mode_out_d;
      pub_out_q   <= pub_out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign relay_bits_o   = relay_out_q;
  assign mode_bits_o    = mode_out_q;
  assign publish_mask_o = pub_out_q;

endmodule
